[design/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, off while in reset
`define ASSERT_CLK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// same, consequent checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/sobel_pkg.sv]
// ---------------------------------------------------------------------------
// sobel package
// shared constants and types of the sobel edge magnitude block
// ---------------------------------------------------------------------------
package sobel_pkg;
  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 2048;
  localparam int SampleBits = 16;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = $clog2(MaxHeight);
  localparam int DimBits    = 12;
  localparam int CountBits  = 23;
  localparam int MagBits    = 19;
  localparam int GradBits   = SampleBits + 3;
  localparam int SumBits    = 2 * GradBits;
  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_THRESH = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [SampleBits-1:0] sample_t;

  // window and position of one output pixel, from front end to math stage
  typedef struct packed {
    logic                valid;
    logic                top_row;
    logic                bot_row;
    logic                left_col;
    logic                right_col;
    logic [RowBits-1:0]  row;
    logic [ColBits-1:0]  col;
    logic                last;
    sample_t [8:0]       win;
  } win_req_t;
endpackage

[design/sobel_line_mem.sv]
// ---------------------------------------------------------------------------
// sobel line memory
// two line buffers packed into one synchronous ram word, registered read
// ---------------------------------------------------------------------------
module sobel_line_mem
  import sobel_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ColBits-1:0] wr_addr,
  input  logic [2*SampleBits-1:0] wr_data,
  input  logic [ColBits-1:0] rd_addr,
  output logic [2*SampleBits-1:0] rd_data
);
  logic [2*SampleBits-1:0] mem [MaxWidth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[design/sobel_isqrt.sv]
// ---------------------------------------------------------------------------
// sobel magnitude unit
// gradients, square sum, threshold and bit-serial floor square root
// ---------------------------------------------------------------------------
module sobel_isqrt
  import sobel_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  win_req_t           req,
  input  logic [MagBits-1:0] thresh,
  input  logic               hold,
  output logic               busy,
  output logic               done,
  output logic [MagBits-1:0] mag,
  output logic [RowBits-1:0] row,
  output logic [ColBits-1:0] col,
  output logic               last
);
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRAD = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam int StepBits = $clog2(SumBits / 2 + 1);

  logic [2:0] state_r, state_nxt;
  logic signed [GradBits-1:0] gx_r, gy_r;
  logic [SumBits-1:0] sum_r, rem_r, bit_r;
  logic [SumBits-1:0] res_r;
  logic [2*MagBits-1:0] thr_sq_r;
  logic [StepBits-1:0] step_r;
  logic [RowBits-1:0] row_r;
  logic [ColBits-1:0] col_r;
  logic last_r, zero_r;
  sample_t [8:0] w_r;
  logic [SumBits-1:0] sq_x, sq_y;

  // window layout: index = 3*column + row, column 0 left, row 0 top
  function automatic logic signed [GradBits-1:0] ext(input sample_t s);
    ext = $signed({{(GradBits-SampleBits){1'b0}}, s});
  endfunction

  assign sq_x = $unsigned(SumBits'(gx_r) * SumBits'(gx_r));
  assign sq_y = $unsigned(SumBits'(gy_r) * SumBits'(gy_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (req.valid) state_nxt = S_GRAD;
      S_GRAD: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_CMP;
      S_CMP:  state_nxt = S_ROOT;
      S_ROOT: if (step_r == '0 && !hold) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        w_r   <= req.win;
        row_r <= req.row;
        col_r <= req.col;
        last_r <= req.last;
        thr_sq_r <= thresh * thresh;
      end
      S_GRAD: begin
        gx_r <= (ext(w_r[6]) - ext(w_r[0])) + (ext(w_r[8]) - ext(w_r[2]))
              + ((ext(w_r[7]) - ext(w_r[1])) <<< 1);
        gy_r <= (ext(w_r[2]) - ext(w_r[0])) + (ext(w_r[8]) - ext(w_r[6]))
              + ((ext(w_r[5]) - ext(w_r[3])) <<< 1);
      end
      S_SQ: begin
        sum_r <= sq_x + sq_y;
      end
      S_CMP: begin
        zero_r <= SumBits'(thr_sq_r) > sum_r;
        rem_r  <= sum_r;
        res_r  <= '0;
        bit_r  <= SumBits'(1) << (SumBits - 2);
        step_r <= StepBits'(SumBits / 2 - 1);
      end
      S_ROOT: begin
        // last step is resolved combinationally and held until taken
        if (step_r != '0) begin
          if (rem_r >= res_r + bit_r) begin
            rem_r <= rem_r - (res_r + bit_r);
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          step_r <= step_r - StepBits'(1);
        end
      end
      default: ;
    endcase
  end

  assign busy = state_r != S_IDLE;
  assign done = state_r == S_ROOT && step_r == '0;
  always_comb begin
    logic [SumBits-1:0] fin;
    fin = (rem_r >= res_r + bit_r) ? (res_r >> 1) + bit_r : res_r >> 1;
    if (zero_r) mag = '0;
    else if (fin > SumBits'({MagBits{1'b1}})) mag = '1;
    else mag = fin[MagBits-1:0];
  end
  assign row  = row_r;
  assign col  = col_r;
  assign last = last_r;

  `ASSERT_CLK(a_done_in_root, done, state_r == S_ROOT, "done outside root phase")
  `ASSERT_NEXT(a_start, state_r == S_IDLE && req.valid, state_r == S_GRAD, "start missed")
  `ASSERT_CLK(a_root_bit, state_r == S_ROOT, $countones(bit_r) == 1, "root bit lost")
endmodule

[design/sobel_edge_magnitude_threshold.sv]
// ---------------------------------------------------------------------------
// sobel edge magnitude threshold
// streaming 3x3 sobel gradient magnitude over a raster frame
// ---------------------------------------------------------------------------
// input transaction: in_tuser = command (0 pixel, 1 drain), in_tdata = sample.
// pixels of one frame arrive in raster order; after the w*h pixels, w+1 drain
// items flush the remaining outputs. a drain before the frame is complete is
// taken and dropped. output j is produced by input item j+w+1.
// output transaction: out_tdata magnitude,row,col; out_tlast marks pixel
// (h-1, w-1). pixels outside the frame are clamped to the edge.
// the two line buffers share one ram read per item and one write per pixel
// (read at the accepting edge, write back with the new sample in the read phase).
// an item that yields an output holds the input until the magnitude unit is
// done; the bit-serial square root settles one result bit per cycle. items
// without output return to idle from the read phase. the output register
// frees the unit so the next item runs while a result waits; the input
// stalls only if a second result is ready first, and the unit then holds it
// until the register frees.
// reset: frame position returns to zero, registers to 640 x 480, threshold 0.
// line contents after reset are undefined until written by the frame.
// a width or height write restarts the frame.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_threshold
  import sobel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // sample
  input  logic                  in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // magnitude, out_row, out_col, zero pad
  output logic                  out_tlast,  // frame_last
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [MagBits-1:0]    cfg_wdata
);
  `include "assert_macros.svh"

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_READ = 2'd1;
  localparam logic [1:0] P_WORK = 2'd2;
  localparam logic [1:0] P_WAIT = 2'd3;

  logic [DimBits-1:0] width_r, height_r;
  logic [MagBits-1:0] thresh_r;
  logic [CountBits-1:0] count_r;
  logic [RowBits-1:0] orow_r;
  logic [ColBits-1:0] ocol_r;
  logic [ColBits-1:0] pcol_r;
  sample_t [5:0] taps_r;
  logic [1:0] ph_r;
  logic cmd_r;
  sample_t smp_r;

  logic [12:0] w_eff, h_eff;
  logic [CountBits-1:0] pixels;
  logic [CountBits-1:0] k_drain;
  logic [ColBits-1:0] rd_addr;
  logic [2*SampleBits-1:0] rd_data;
  logic mem_we;
  win_req_t req;
  logic mu_busy, mu_done, mu_last, mu_hold;
  logic [MagBits-1:0] mu_mag;
  logic [RowBits-1:0] mu_row;
  logic [ColBits-1:0] mu_col;
  logic ov_r;
  logic [MagBits-1:0] om_r;
  logic [RowBits-1:0] or_r;
  logic [ColBits-1:0] oc_r;
  logic ol_r;
  logic accept, is_px, in_flush, has_out;
  sample_t [2:0] fresh;
  sample_t [2:0] c0, c1, c2;

  // clamp geometry to 1..max
  always_comb begin
    w_eff = (width_r == '0) ? 13'd1 : (width_r > 12'(MaxWidth) ? 13'(MaxWidth) : {1'b0, width_r});
    h_eff = (height_r == '0) ? 13'd1
          : (height_r > 12'(MaxHeight) ? 13'(MaxHeight) : {1'b0, height_r});
  end

  always_ff @(posedge clk) begin
    pixels <= CountBits'(w_eff) * CountBits'(h_eff);
  end

  assign in_tready = ph_r == P_IDLE && rst_n;
  assign accept    = in_tvalid && in_tready;
  assign in_flush  = count_r >= pixels;
  assign is_px     = !in_flush;
  assign k_drain   = count_r - pixels;
  assign has_out   = count_r >= CountBits'(w_eff) + CountBits'(1);

  // read address: pixel column, or drain column; one read per item
  assign rd_addr = is_px ? pcol_r : k_drain[ColBits-1:0];
  assign mem_we  = ph_r == P_READ && is_px && cmd_r == CMD_PIXEL;

  // middle line moves down to the older line, new sample becomes the middle
  sobel_line_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (pcol_r),
    .wr_data ({smp_r, rd_data[2*SampleBits-1:SampleBits]}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // fresh column: low half older line, high half middle line
  always_comb begin
    if (is_px) begin
      fresh = {smp_r, rd_data[2*SampleBits-1:SampleBits], rd_data[SampleBits-1:0]};
    end else if (k_drain < CountBits'(w_eff)) begin
      fresh = {rd_data[2*SampleBits-1:SampleBits], rd_data[2*SampleBits-1:SampleBits],
               rd_data[SampleBits-1:0]};
    end else begin
      fresh = '0;
    end
  end

  // clamp window to frame edges
  always_comb begin
    c1 = taps_r[5:3];
    c0 = (ocol_r == '0) ? taps_r[5:3] : taps_r[2:0];
    c2 = (13'(ocol_r) == w_eff - 13'd1) ? taps_r[5:3] : fresh;
    if (orow_r == '0) begin
      c0[0] = c0[1]; c1[0] = c1[1]; c2[0] = c2[1];
    end
    if (13'(orow_r) == h_eff - 13'd1) begin
      c0[2] = c0[1]; c1[2] = c1[1]; c2[2] = c2[1];
    end
    req.valid     = ph_r == P_READ && !(is_px && cmd_r == CMD_DRAIN) && has_out;
    req.top_row   = orow_r == '0;
    req.bot_row   = 13'(orow_r) == h_eff - 13'd1;
    req.left_col  = ocol_r == '0;
    req.right_col = 13'(ocol_r) == w_eff - 13'd1;
    req.row       = orow_r;
    req.col       = ocol_r;
    req.last      = req.bot_row && req.right_col;
    req.win       = {c2, c1, c0};
  end

  // unit keeps its finished result while the output register is blocked
  assign mu_hold = ov_r && !out_tready;

  sobel_isqrt u_mag (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .thresh (thresh_r),
    .hold   (mu_hold),
    .busy   (mu_busy),
    .done   (mu_done),
    .mag    (mu_mag),
    .row    (mu_row),
    .col    (mu_col),
    .last   (mu_last)
  );

  // item sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      width_r <= 12'd640;
      height_r <= 12'd480;
      thresh_r <= '0;
      count_r <= '0;
      orow_r <= '0;
      ocol_r <= '0;
      pcol_r <= '0;
      taps_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH, REG_HEIGHT: begin
            if (cfg_index == REG_WIDTH) width_r <= cfg_wdata[DimBits-1:0];
            else height_r <= cfg_wdata[DimBits-1:0];
            count_r <= '0; orow_r <= '0; ocol_r <= '0; pcol_r <= '0;
          end
          REG_THRESH: thresh_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (ph_r)
        P_IDLE: if (accept) begin
          ph_r <= P_READ;
          cmd_r <= in_tuser;
          smp_r <= in_tdata;
        end
        P_READ: begin
          if (is_px && cmd_r == CMD_DRAIN) begin
            ph_r <= P_IDLE;
          end else begin
            ph_r <= has_out ? P_WORK : P_IDLE;
            taps_r <= {fresh, taps_r[5:3]};
            if (is_px) begin
              pcol_r <= (13'(pcol_r) == w_eff - 13'd1) ? '0 : pcol_r + ColBits'(1);
            end
            if (has_out) begin
              if (13'(ocol_r) == w_eff - 13'd1) begin
                ocol_r <= '0; orow_r <= orow_r + RowBits'(1);
              end else begin
                ocol_r <= ocol_r + ColBits'(1);
              end
            end
            if (count_r + CountBits'(1) >= pixels + CountBits'(w_eff) + CountBits'(1)) begin
              count_r <= '0; orow_r <= '0; ocol_r <= '0; pcol_r <= '0;
            end else begin
              count_r <= count_r + CountBits'(1);
            end
          end
        end
        P_WORK: ph_r <= P_WAIT;
        P_WAIT: if (mu_done && !(ov_r && !out_tready)) ph_r <= P_IDLE;
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (mu_done && ph_r == P_WAIT && !(ov_r && !out_tready)) begin
      ov_r <= 1'b1;
      om_r <= mu_mag; or_r <= mu_row; oc_r <= mu_col; ol_r <= mu_last;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, oc_r, or_r, om_r};
  assign out_tlast  = ol_r;

  `ASSERT_CLK(a_ready_idle, in_tready, !mu_busy || ph_r == P_IDLE, "ready while busy")
  `ASSERT_CLK(a_wait_busy, ph_r == P_WAIT, mu_busy, "waiting on idle unit")
  `ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
endmodule

[tb/tb_sobel_edge_magnitude_threshold.sv]
// ---------------------------------------------------------------------------
// sobel edge magnitude testbench
// drives raster frames and drain items at random pace, predicts every
// thresholded gradient magnitude with its own line buffers and checks the
// result stream transaction by transaction
// ---------------------------------------------------------------------------
module tb_sobel_edge_magnitude_threshold;
  timeunit 1ns;
  timeprecision 1ps;
  import sobel_pkg::*;

  // expected output pixel
  typedef struct packed {
    logic [MagBits-1:0] mag;
    logic [10:0]        row;
    logic [10:0]        col;
    logic               last;
  } pix_result_t;

  // scoreboard: own copy of the line buffers, taps and frame position
  class sobel_scoreboard;
    sample_t         upper_line[MaxWidth];
    sample_t         mid_line[MaxWidth];
    sample_t         taps[6];
    int unsigned     pos_count;
    int unsigned     pos_row;
    int unsigned     pos_col;
    int unsigned     width_reg;
    int unsigned     height_reg;
    int unsigned     thresh_reg;
    pix_result_t     pending[$];
    int              errors;

    function new();
      width_reg = 640;
      height_reg = 480;
      thresh_reg = 0;
      errors = 0;
      pos_count = 0;
      pos_row = 0;
      pos_col = 0;
      foreach (taps[i]) taps[i] = '0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r = r + (64'd1 << b);
      end
      return r;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
      if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
        if (idx == REG_WIDTH) width_reg = val & 12'hfff;
        else height_reg = val & 12'hfff;
        pos_count = 0;
        pos_row = 0;
        pos_col = 0;
      end else if (idx == REG_THRESH) begin
        thresh_reg = val & 19'h7ffff;
      end
    endfunction

    // note one accepted input transaction, queue its result if any
    function void note_input(logic cmd, sample_t smp);
      int unsigned w, h, npix, k, pc;
      sample_t fresh[3];
      longint signed win[3][3];
      longint signed gx, gy;
      longint unsigned sum, mag;
      pix_result_t res;
      w = clamp_dim(width_reg, MaxWidth);
      h = clamp_dim(height_reg, MaxHeight);
      npix = w * h;
      k = pos_count;
      if (k < npix) begin
        if (cmd == CMD_DRAIN) return;
        pc = k % w;
        fresh[0] = upper_line[pc];
        fresh[1] = mid_line[pc];
        fresh[2] = smp;
        upper_line[pc] = mid_line[pc];
        mid_line[pc] = smp;
      end else begin
        pc = k - npix;
        if (pc < w) begin
          fresh[0] = upper_line[pc];
          fresh[1] = mid_line[pc];
          fresh[2] = mid_line[pc];
        end else begin
          fresh[0] = '0;
          fresh[1] = '0;
          fresh[2] = '0;
        end
      end
      if (k >= w + 1) begin
        // build the clamped 3x3 window, win[column][row]
        for (int i = 0; i < 3; i++) begin
          win[1][i] = taps[3 + i];
          win[0][i] = (pos_col == 0) ? taps[3 + i] : taps[i];
          win[2][i] = (pos_col == w - 1) ? taps[3 + i] : fresh[i];
        end
        for (int i = 0; i < 3; i++) begin
          if (pos_row == 0) win[i][0] = win[i][1];
          if (pos_row == h - 1) win[i][2] = win[i][1];
        end
        gx = (win[2][0] - win[0][0]) + (win[2][2] - win[0][2])
           + 2 * (win[2][1] - win[0][1]);
        gy = (win[0][2] - win[0][0]) + (win[2][2] - win[2][0])
           + 2 * (win[1][2] - win[1][0]);
        sum = gx * gx + gy * gy;
        if (sum < longint'(thresh_reg) * thresh_reg) mag = 0;
        else begin
          mag = isqrt(sum);
          if (mag > 19'h7ffff) mag = 19'h7ffff;
        end
        res.mag = mag[MagBits-1:0];
        res.row = pos_row[10:0];
        res.col = pos_col[10:0];
        res.last = (pos_row == h - 1 && pos_col == w - 1);
        pending.push_back(res);
        pos_col++;
        if (pos_col >= w) begin
          pos_col = 0;
          pos_row++;
        end
      end
      taps[0] = taps[3];
      taps[1] = taps[4];
      taps[2] = taps[5];
      taps[3] = fresh[0];
      taps[4] = fresh[1];
      taps[5] = fresh[2];
      pos_count = k + 1;
      if (pos_count >= npix + w + 1) begin
        pos_count = 0;
        pos_row = 0;
        pos_col = 0;
      end
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endfunction

    // check one accepted output transaction against the oldest expectation
    function void check_result(logic [47:0] data, logic last);
      pix_result_t want;
      if (pending.size() == 0) begin
        report("unexpected output magnitude", data[18:0], 0);
        return;
      end
      want = pending.pop_front();
      if (data[18:0] !== want.mag) report("magnitude", data[18:0], want.mag);
      if (data[29:19] !== want.row) report("row", data[29:19], want.row);
      if (data[40:30] !== want.col) report("col", data[40:30], want.col);
      if (data[47:41] !== '0) report("pad", data[47:41], 0);
      if (last !== want.last) report("frame_last", last, want.last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // sample
  logic                  in_tuser;   // command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [47:0]           out_tdata;  // magnitude, out_row, out_col, zero pad
  logic                  out_tlast;  // frame_last
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [MagBits-1:0]    cfg_wdata;

  sobel_scoreboard sb;
  bit              calm_phase;   // no idling at the end of the run
  bit              sink_stalls;  // random stall enable on the result side

  sobel_edge_magnitude_threshold dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: sample at rising edge, stall in random bursts
  initial begin
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (sink_stalls && !calm_phase && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 6);
      out_tready = (stall_left == 0);
    end
  end

  // send one transaction, with an occasional idle burst before it
  task automatic send_item(logic cmd, sample_t smp);
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, smp);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    // items without output may still be in flight
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= MagBits'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return sample_t'($urandom_range(0, 15));
      default: return sample_t'($urandom());
    endcase
  endfunction

  // whole frame: pixels, then the flush drains
  task automatic send_frame(int unsigned w, int unsigned h);
    for (int i = 0; i < w * h; i++) begin
      // stray early drains are dropped by the block
      if ($urandom_range(0, 19) == 0) send_item(CMD_DRAIN, sample_t'($urandom()));
      send_item(CMD_PIXEL, pick_sample());
    end
    for (int i = 0; i <= w; i++) begin
      // a pixel during flush acts as a drain
      if ($urandom_range(0, 9) == 0) send_item(CMD_PIXEL, sample_t'($urandom()));
      else send_item(CMD_DRAIN, sample_t'($urandom()));
    end
  endtask

  initial begin
    int unsigned w, h, sent;
    sb = new();
    calm_phase = 0;
    sink_stalls = 1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_PIXEL;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: tiny frames, extreme samples, zero sizes, max threshold
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_THRESH, 0);
    send_item(CMD_DRAIN, 16'h1234);
    for (int i = 0; i < 9; i++) send_item(CMD_PIXEL, (i % 2) ? 16'hffff : 16'h0000);
    for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, 16'h0);
    go_idle();
    write_reg(REG_WIDTH, 0);      // used as one
    write_reg(REG_HEIGHT, 1);
    send_item(CMD_PIXEL, 16'hffff);
    send_item(CMD_DRAIN, 16'h0);
    send_item(CMD_PIXEL, 16'h5555);
    go_idle();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 0);     // used as one
    write_reg(REG_THRESH, 19'h7ffff);
    send_frame(2, 1);
    go_idle();
    write_reg(REG_THRESH, 100);
    send_frame(1, 2);
    go_idle();

    // restart mid-frame by a geometry write
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 3);
    for (int i = 0; i < 7; i++) send_item(CMD_PIXEL, pick_sample());
    go_idle();
    write_reg(REG_HEIGHT, 3);
    send_frame(4, 3);
    go_idle();

    // one wide single-row frame and the first 40 rows of a tall single-column frame
    write_reg(REG_WIDTH, 400);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_THRESH, $urandom_range(0, 20000));
    send_frame(400, 1);
    go_idle();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 12'hfff);
    write_reg(REG_THRESH, 0);
    sink_stalls = 0;
    send_frame(1, 40);
    sink_stalls = 1;
    go_idle();
    write_reg(REG_HEIGHT, 40);

    // random frames of small size
    sent = 0;
    while (sent < 750) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      if (sent > 620) calm_phase = 1;
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      case ($urandom_range(0, 3))
        0: write_reg(REG_THRESH, 0);
        1: write_reg(REG_THRESH, $urandom_range(0, 19'h7ffff));
        default: write_reg(REG_THRESH, $urandom_range(0, 150000));
      endcase
      send_frame(w, h);
      sent += w * h + w + 1;
      // registers change only with nothing in flight
      go_idle();
    end

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
